@@ src/controller_pak_block_access_crc8_macros.svh @@
// assertion helpers for the pak block access checker
// both sample on clk and stay quiet while rst_n is low
`ifndef CONTROLLER_PAK_BLOCK_ACCESS_CRC8_MACROS_SVH
`define CONTROLLER_PAK_BLOCK_ACCESS_CRC8_MACROS_SVH

// consequent checked in the same cycle
`define CPBAC_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpbac check failed");

// consequent checked in the next cycle
`define CPBAC_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpbac check failed");

`endif

@@ src/cpbac_pkg.sv @@
`timescale 1ns / 1ps
package cpbac_pkg;

    // block geometry
    localparam int BLOCK_BYTES = 32;
    localparam int WORD_BYTES  = 8;
    localparam int WORD_W      = 8 * WORD_BYTES;
    localparam int BEATS       = BLOCK_BYTES / WORD_BYTES;
    localparam int BEAT_W      = $clog2(BEATS);
    localparam int BLK_LSB     = $clog2(BLOCK_BYTES);
    localparam int BLK_W       = 15 - BLK_LSB;

    // address decode
    localparam logic [15:0] PROBE_ADDR = 16'h8001;
    localparam logic [15:0] BLOCK_MASK = 16'hFFE0;
    localparam logic [15:0] LAST_BLOCK = 16'h7FE0;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        KIND_STORE  = 2'd0,
        KIND_RUMBLE = 2'd1,
        KIND_PROBE  = 2'd2
    } kind_t;

    // crc
    localparam logic [7:0] CRC_POLY = 8'h85;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // formatted image
    localparam int          HEADER_WORDS = 34;
    localparam int          HDR_IDX_W    = 6;
    localparam logic [63:0] FILL_WORD    = 64'h0003000300030003;
    localparam logic [63:0] HDR_A        = 64'hFFFFFFFF051A5F13;
    localparam logic [63:0] HDR_B        = 64'hFFFFFFFFFFFFFFFF;
    localparam logic [63:0] HDR_C        = 64'hFFFF01FF662599CD;
    localparam logic [63:0] HDR_TAIL     = 64'h0071000300030003;

    // word of the formatted header at a word index below HEADER_WORDS
    function automatic logic [63:0] fmt_word(input logic [HDR_IDX_W-1:0] idx);
        logic [63:0] w;
        case (idx)
            6'd0:  w = 64'h8101020304050607;
            6'd1:  w = 64'h08090A0B0C0D0E0F;
            6'd2:  w = 64'h1011121314151617;
            6'd3:  w = 64'h18191A1B1C1D1E1F;
            6'd4, 6'd12, 6'd16, 6'd24: w = HDR_A;
            6'd6, 6'd14, 6'd18, 6'd26: w = HDR_B;
            6'd7, 6'd15, 6'd19, 6'd27: w = HDR_C;
            6'd32: w = HDR_TAIL;
            6'd33: w = FILL_WORD;
            default: w = '0;
        endcase
        return w;
    endfunction

    // one byte through the crc register, msb first; the byte lands on top
    // of eight zero shifts since no data bit reaches the tap within a byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 8'h00)
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c ^ d;
    endfunction

    // one 64-bit word, byte in bits 63:56 first
    function automatic logic [7:0] crc8_word(input logic [7:0] crc, input logic [63:0] w);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < WORD_BYTES; i++) begin
            c = crc8_byte(c, w[63 - 8*i -: 8]);
        end
        return c;
    endfunction

endpackage

@@ src/cpbac_if.sv @@
`timescale 1ns / 1ps
// request channel: one block access per transaction
interface cpbac_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [1:0]  pak_port;
    logic [15:0] pak_address;
    logic [63:0] write_word_0;
    logic [63:0] write_word_1;
    logic [63:0] write_word_2;
    logic [63:0] write_word_3;

    modport source (
        output valid, command, pak_port, pak_address,
        output write_word_0, write_word_1, write_word_2, write_word_3,
        input  ready
    );
    modport sink (
        input  valid, command, pak_port, pak_address,
        input  write_word_0, write_word_1, write_word_2, write_word_3,
        output ready
    );
endinterface

// response channel: block data, crc and access kind
interface cpbac_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_word_0;
    logic [63:0] read_word_1;
    logic [63:0] read_word_2;
    logic [63:0] read_word_3;
    logic [7:0]  block_crc;
    logic [1:0]  access_kind;

    modport source (
        output valid, read_word_0, read_word_1, read_word_2, read_word_3,
        output block_crc, access_kind,
        input  ready
    );
    modport sink (
        input  valid, read_word_0, read_word_1, read_word_2, read_word_3,
        input  block_crc, access_kind,
        output ready
    );
endinterface

@@ src/controller_pak_block_access_crc8.sv @@
`timescale 1ns / 1ps
// Block access to NUM_PORTS controller paks of PAK_BYTES bytes each, with CRC-8.
// req carries one 32-byte block read or write per transaction: command,
// pak_port, pak_address and four big-endian write words. rsp returns the
// block (read data, or the write data echoed), its CRC-8 and the access kind.
// Probe and rumble addresses never touch the store and read as zeros.
// After reset the store is loaded with the formatted image, one 64-bit word
// per cycle over all NUM_PORTS * PAK_BYTES / 8 words (16384 at the defaults),
// with req.ready low; no transaction is taken before that pass ends.
// A request passes ST_ADDR for the block index, ST_ISSUE for the four
// 64-bit beats on the single RAM port, ST_LAST for the last beat's CRC and
// ST_DONE, which loads the output register; the next request is taken only
// with that load or later.
// A stalled rsp holds its result in the output register; the block still
// takes one more request, works it through and holds it until rsp frees up.
module controller_pak_block_access_crc8 #(
    parameter int NUM_PORTS = 4,
    parameter int PAK_BYTES = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    cpbac_req_if.sink   req,
    cpbac_rsp_if.source rsp
);
    import cpbac_pkg::*;

    localparam int WORDS_PER_PAK = PAK_BYTES / WORD_BYTES;
    localparam int STORE_WORDS   = NUM_PORTS * WORDS_PER_PAK;
    localparam int ADDR_W        = $clog2(STORE_WORDS);

    typedef enum logic [5:0] {
        ST_FILL  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_ADDR  = 6'b000100,
        ST_ISSUE = 6'b001000,
        ST_LAST  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [BEAT_W-1:0]   beat_reg, beat_next;
    logic                accept;
    logic                out_free;
    logic                load_out;
    logic                is_store;

    logic                cmd_reg;
    logic [WORD_W-1:0]   wdata_reg [BEATS];
    logic [ADDR_W-1:0]   base_reg;
    logic                proc_valid_reg;
    logic [BEAT_W-1:0]   proc_beat_reg;
    logic                rd_sel_reg;
    logic [WORD_W-1:0]   issue_word_reg;
    logic [WORD_W-1:0]   data_reg [BEATS];
    logic [7:0]          crc_reg;

    logic                rsp_valid_reg;
    logic [WORD_W-1:0]   rsp_word_reg [BEATS];
    logic [7:0]          rsp_crc_reg;
    kind_t               rsp_kind_reg;

    kind_t               dec_kind;
    logic [ADDR_W-1:0]   dec_base;
    logic                fill_busy;
    logic [ADDR_W-1:0]   fill_addr;
    logic [WORD_W-1:0]   fill_data;

    logic                ram_en;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   cur_wword;
    logic [WORD_W-1:0]   proc_word;

    cpbac_dec #(
        .NUM_PORTS (NUM_PORTS),
        .PAK_BYTES (PAK_BYTES)
    ) u_dec (
        .clk         (clk),
        .cap         (accept),
        .pak_port    (req.pak_port),
        .pak_address (req.pak_address),
        .kind        (dec_kind),
        .base        (dec_base)
    );

    cpbac_fill #(
        .NUM_PORTS (NUM_PORTS),
        .PAK_BYTES (PAK_BYTES)
    ) u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (fill_busy),
        .addr  (fill_addr),
        .data  (fill_data)
    );

    cpbac_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // handshake
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign load_out  = (state_reg == ST_DONE) && out_free;
    assign req.ready = (state_reg == ST_IDLE) || load_out;
    assign accept    = req.valid && req.ready;
    assign is_store  = (dec_kind == KIND_STORE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        beat_next  = beat_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (!fill_busy)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                beat_next  = '0;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                beat_next = beat_reg + 1'b1;
                if (beat_reg == BEAT_W'(BEATS - 1))
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (accept)
                    state_next = ST_ADDR;
                else if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory port: fill pass, then the beats of one block
    assign cur_wword = wdata_reg[beat_reg];
    assign ram_en    = fill_busy || ((state_reg == ST_ISSUE) && is_store);
    assign ram_we    = fill_busy || (cmd_reg == CMD_WRITE);
    assign ram_addr  = fill_busy ? fill_addr : base_reg + ADDR_W'(beat_reg);
    assign ram_wdata = fill_busy ? fill_data : cur_wword;

    // data of the beat in the cycle after its issue
    assign proc_word = rd_sel_reg ? ram_rdata : issue_word_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            beat_reg       <= '0;
            proc_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            beat_reg       <= beat_next;
            proc_valid_reg <= (state_reg == ST_ISSUE);
            if (load_out)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // capture the transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= req.command;
            wdata_reg[0] <= req.write_word_0;
            wdata_reg[1] <= req.write_word_1;
            wdata_reg[2] <= req.write_word_2;
            wdata_reg[3] <= req.write_word_3;
        end
        if (state_reg == ST_ADDR)
            base_reg <= dec_base;
    end

    // beat pipeline and crc accumulation
    always_ff @(posedge clk)
    begin
        proc_beat_reg  <= beat_reg;
        rd_sel_reg     <= (state_reg == ST_ISSUE) && is_store && (cmd_reg == CMD_READ);
        issue_word_reg <= (cmd_reg == CMD_WRITE) ? cur_wword : '0;
        if (accept)
            crc_reg <= '0;
        else if (proc_valid_reg)
            crc_reg <= crc8_word(crc_reg, proc_word);
        if (proc_valid_reg)
            data_reg[proc_beat_reg] <= proc_word;
    end

    // output register, crc closed with eight zero bits
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int i = 0; i < BEATS; i++)
            begin
                rsp_word_reg[i] <= data_reg[i];
            end
            rsp_crc_reg  <= crc8_byte(crc_reg, 8'h00);
            rsp_kind_reg <= dec_kind;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_word_0 = rsp_word_reg[0];
    assign rsp.read_word_1 = rsp_word_reg[1];
    assign rsp.read_word_2 = rsp_word_reg[2];
    assign rsp.read_word_3 = rsp_word_reg[3];
    assign rsp.block_crc   = rsp_crc_reg;
    assign rsp.access_kind = rsp_kind_reg;

endmodule

@@ src/cpbac_ram.sv @@
`timescale 1ns / 1ps
module cpbac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/cpbac_dec.sv @@
`timescale 1ns / 1ps
module cpbac_dec #(
    parameter int NUM_PORTS = 4,
    parameter int PAK_BYTES = 32768
) (
    input  logic                                              clk,
    input  logic                                              cap,
    input  logic [1:0]                                        pak_port,
    input  logic [15:0]                                       pak_address,
    output cpbac_pkg::kind_t                                  kind,
    output logic [$clog2(NUM_PORTS*PAK_BYTES/cpbac_pkg::WORD_BYTES)-1:0] base
);
    import cpbac_pkg::*;

    localparam int WORDS_PER_PAK = PAK_BYTES / WORD_BYTES;
    localparam int ADDR_W        = $clog2(NUM_PORTS * WORDS_PER_PAK);
    localparam int BLOCKS        = PAK_BYTES / BLOCK_BYTES;
    localparam int QSHIFT        = 21;
    localparam int RECIP         = ((1 << QSHIFT) + BLOCKS - 1) / BLOCKS;
    localparam int RECIP_W       = $clog2(RECIP + 1);
    localparam int PROD_W        = BLK_W + RECIP_W;
    localparam int QC_W          = 2 * BLK_W + 1;

    kind_t              kind_reg;
    logic [BLK_W-1:0]   blk_reg;
    logic [BLK_W-1:0]   q_reg;
    logic [ADDR_W-1:0]  port_off_reg;
    logic [1:0]         port_mod;
    logic [BLK_W-1:0]   blk_in;
    logic [PROD_W-1:0]  q_prod;
    logic [QC_W-1:0]    qc_full;
    logic [BLK_W-1:0]   rem_raw;
    logic [BLK_W-1:0]   rem;
    kind_t              kind_in;

    // access kind from the raw address
    always_comb
    begin
        if (pak_address == PROBE_ADDR)
            kind_in = KIND_PROBE;
        else if ((pak_address & BLOCK_MASK) > LAST_BLOCK)
            kind_in = KIND_RUMBLE;
        else
            kind_in = KIND_STORE;
    end

    // port wraps modulo the pak count
    always_comb
    begin
        if (NUM_PORTS == 1)
            port_mod = '0;
        else if ({1'b0, pak_port} >= 3'(NUM_PORTS))
            port_mod = 2'(3'({1'b0, pak_port}) - 3'(NUM_PORTS));
        else
            port_mod = pak_port;
    end

    // quotient by reciprocal, exact for block numbers below 2^BLK_W
    assign blk_in = pak_address[BLK_LSB +: BLK_W];
    assign q_prod = PROD_W'(blk_in) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            kind_reg     <= kind_in;
            blk_reg      <= blk_in;
            q_reg        <= BLK_W'(q_prod >> QSHIFT);
            port_off_reg <= ADDR_W'(port_mod) * ADDR_W'(WORDS_PER_PAK);
        end
    end

    // remainder with one correction step, then word base of the block
    assign qc_full = QC_W'(q_reg) * QC_W'(BLOCKS);
    assign rem_raw = blk_reg - BLK_W'(qc_full);
    assign rem     = ({1'b0, rem_raw} >= (BLK_W + 1)'(BLOCKS)) ?
                     rem_raw - BLK_W'(BLOCKS) : rem_raw;

    assign kind = kind_reg;
    assign base = port_off_reg + ADDR_W'({rem, {BEAT_W{1'b0}}});

endmodule

@@ src/cpbac_fill.sv @@
`timescale 1ns / 1ps
module cpbac_fill #(
    parameter int NUM_PORTS = 4,
    parameter int PAK_BYTES = 32768
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    output logic                                              busy,
    output logic [$clog2(NUM_PORTS*PAK_BYTES/cpbac_pkg::WORD_BYTES)-1:0] addr,
    output logic [63:0]                                       data
);
    import cpbac_pkg::*;

    localparam int WORDS_PER_PAK = PAK_BYTES / WORD_BYTES;
    localparam int STORE_WORDS   = NUM_PORTS * WORDS_PER_PAK;
    localparam int ADDR_W        = $clog2(STORE_WORDS);
    localparam int OFF_W         = $clog2(WORDS_PER_PAK);

    logic              busy_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [OFF_W-1:0]  off_reg;

    // one word per cycle over the whole store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
            off_reg  <= '0;
        end
        else if (busy_reg)
        begin
            addr_reg <= addr_reg + 1'b1;
            if (off_reg == OFF_W'(WORDS_PER_PAK - 1))
                off_reg <= '0;
            else
                off_reg <= off_reg + 1'b1;
            if (addr_reg == ADDR_W'(STORE_WORDS - 1))
                busy_reg <= 1'b0;
        end
    end

    // header words at the start of each pak, fill pattern after
    assign data = (off_reg < OFF_W'(HEADER_WORDS)) ?
                  fmt_word(HDR_IDX_W'(off_reg)) : FILL_WORD;
    assign busy = busy_reg;
    assign addr = addr_reg;

endmodule

@@ src/cpbac_chk.sv @@
`timescale 1ns / 1ps
`include "controller_pak_block_access_crc8_macros.svh"
module cpbac_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] read_word_0,
    input logic [63:0] read_word_1,
    input logic [63:0] read_word_2,
    input logic [63:0] read_word_3,
    input logic [7:0]  block_crc,
    input logic [1:0]  access_kind
);

    // a pending result stays and holds its payload
    `CPBAC_HOLDS(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `CPBAC_HOLDS(a_rsp_stable, rsp_valid && !rsp_ready, $stable(read_word_0) && $stable(read_word_1) && $stable(read_word_2) && $stable(read_word_3) && $stable(block_crc) && $stable(access_kind))

    // the block is busy right after it takes a request
    `CPBAC_HOLDS(a_busy_after_accept, req_valid && req_ready, !req_ready)

    // an all-zero block has a zero crc
    `CPBAC_IMPLIES(a_zero_crc, rsp_valid && (read_word_0 == 64'h0) && (read_word_1 == 64'h0) && (read_word_2 == 64'h0) && (read_word_3 == 64'h0), block_crc == 8'h00)

endmodule

bind controller_pak_block_access_crc8 cpbac_chk u_cpbac_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .read_word_0 (rsp.read_word_0),
    .read_word_1 (rsp.read_word_1),
    .read_word_2 (rsp.read_word_2),
    .read_word_3 (rsp.read_word_3),
    .block_crc   (rsp.block_crc),
    .access_kind (rsp.access_kind)
);
